[rtl/sacache_pkg.sv]
package sacache_pkg;

    localparam int SETS_DEF       = 128;
    localparam int WAYS_DEF       = 8;
    localparam int LINE_BYTES_DEF = 64;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RESP  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_UNC   = 2'd2,
        KIND_WRITE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_FILL = 2'd1,
        PEND_UNC  = 2'd2
    } t_pend;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_TAG  = 2'd1,
        ST_DATA = 2'd2,
        ST_EMIT = 2'd3
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] addr;
        logic [2:0]  size;
        logic [31:0] data;
    } t_res;

    // Sizes of zero count as one byte and sizes above four as four.
    function automatic logic [2:0] clamp_size(logic [2:0] s);
        logic [2:0] r;
        if (s == 3'd0) begin
            r = 3'd1;
        end else if (s > 3'd4) begin
            r = 3'd4;
        end else begin
            r = s;
        end
        return r;
    endfunction

    function automatic logic [31:0] size_mask(logic [2:0] s);
        logic [31:0] m;
        unique case (s)
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

endpackage

[rtl/sacache_tags.sv]
module sacache_tags #(
    parameter int SETS  = sacache_pkg::SETS_DEF,
    parameter int WAYS  = sacache_pkg::WAYS_DEF,
    parameter int TAG_W = 19,
    parameter int SW    = (SETS > 1) ? $clog2(SETS) : 1,
    parameter int WW    = (WAYS > 1) ? $clog2(WAYS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [SW-1:0]    i_rd_set,
    input  logic [SW-1:0]    i_cmp_set,
    input  logic [TAG_W-1:0] i_cmp_tag,
    input  logic             i_alloc,
    input  logic             i_fill_done,
    input  logic [SW-1:0]    i_fill_set,
    input  logic [WW-1:0]    i_fill_way,
    output logic             o_ready,
    output logic             o_hit,
    output logic [WW-1:0]    o_hit_way,
    output logic [WW-1:0]    o_victim_way
);
    import sacache_pkg::*;

    logic [WAYS-1:0][TAG_W-1:0] r_tag_mem [SETS];
    logic [WAYS-1:0][TAG_W-1:0] r_tag_rd;
    logic [WAYS-1:0][TAG_W-1:0] n_row;
    logic [WAYS-1:0]            r_valid_mem [SETS];
    logic [WAYS-1:0]            r_valid_rd;
    logic [WAYS-1:0]            row_valid;
    logic                       r_clr_busy;
    logic [SW-1:0]              r_clr_set;
    logic [15:0]                r_lfsr;
    logic [15:0]                lfsr_adv;
    logic                       inv_found;
    logic [WW-1:0]              inv_way;

    assign row_valid = r_valid_rd;
    assign o_ready   = !r_clr_busy;
    assign lfsr_adv  = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[15:1]};

    always_comb begin
        o_hit     = 1'b0;
        o_hit_way = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row_valid[w] && r_tag_rd[w] == i_cmp_tag) begin
                o_hit     = 1'b1;
                o_hit_way = WW'(w);
            end
            if (!row_valid[w]) begin
                inv_found = 1'b1;
                inv_way   = WW'(w);
            end
        end
    end

    assign o_victim_way = inv_found ? inv_way : (lfsr_adv[WW-1:0] & WW'(WAYS - 1));

    always_comb begin
        n_row               = r_tag_rd;
        n_row[o_victim_way] = i_cmp_tag;
    end

    always_ff @(posedge i_clk) begin
        if (i_alloc) begin
            r_tag_mem[i_cmp_set] <= n_row;
        end
        r_tag_rd <= r_tag_mem[i_rd_set];
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_valid_mem[r_clr_set] <= '0;
        end else if (i_alloc) begin
            r_valid_mem[i_cmp_set][o_victim_way] <= 1'b0;
        end else if (i_fill_done) begin
            r_valid_mem[i_fill_set][i_fill_way] <= 1'b1;
        end
        r_valid_rd <= r_valid_mem[i_rd_set];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_set  <= '0;
            r_lfsr     <= LFSR_SEED;
        end else begin
            if (r_clr_busy) begin
                r_clr_set <= r_clr_set + SW'(1);
                if (r_clr_set == SW'(SETS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_alloc && !inv_found) begin
                r_lfsr <= lfsr_adv;
            end
        end
    end

endmodule

[rtl/set_assoc_write_through_cache.sv]
// Write-through, no-write-allocate set-associative cache with random
// replacement. Tags sit in a synchronous memory holding one row of all ways
// per set, valid bits in a second synchronous memory with one bit per way,
// and line data in a word-wide synchronous memory. After reset a clearing
// pass empties the valid memory one set per cycle, so the input is held off
// until all SETS sets (128 by default) are clear. A read hit goes from its
// transfer to the result register through a tag read, one or two data word
// reads and a result load, because a hit walks the tag memory and then the
// single data memory port one word at a time. A write reads, merges and
// writes back each covered word that hits, with a second tag lookup when it
// spans two words. A read miss issues its line fill request after the tag
// lookup; the response words are then written into the line one by one,
// and the last one produces the read data.
// A read near the end of a line goes out as an uncached request and its single
// response word comes back as the read data. Accesses that arrive while a
// fill or an uncached read is outstanding are dropped without a result. The
// result register lets a new transfer in while the last result still waits.
module set_assoc_write_through_cache #(
    parameter int SETS       = sacache_pkg::SETS_DEF,
    parameter int WAYS       = sacache_pkg::WAYS_DEF,
    parameter int LINE_BYTES = sacache_pkg::LINE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // addr[31:0], size[34:32], data[66:35], zero pad
    input  logic [1:0]  i_s_tuser,  // op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,  // out_addr[31:0], out_size[34:32], out_data[66:35]
    output logic [1:0]  o_m_tuser   // kind
);
    import sacache_pkg::*;

    localparam int OB    = $clog2(LINE_BYTES);
    localparam int SB    = $clog2(SETS);
    localparam int SW    = (SETS > 1) ? SB : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TW    = 32 - OB - SB;
    localparam int WPL   = LINE_BYTES / 4;
    localparam int CW    = $clog2(WPL);
    localparam int DEPTH = SETS * WAYS * WPL;
    localparam int DW    = $clog2(DEPTH);

    function automatic logic [SW-1:0] f_set(logic [31:0] a);
        return SW'((a >> OB) & 32'(SETS - 1));
    endfunction

    function automatic logic [TW-1:0] f_tag(logic [31:0] a);
        return TW'(a >> (OB + SB));
    endfunction

    function automatic logic [CW-1:0] f_word(logic [31:0] a);
        return CW'(a >> 2);
    endfunction

    function automatic logic [DW-1:0] f_didx(logic [SW-1:0] s, logic [WW-1:0] w,
                                             logic [CW-1:0] k);
        return DW'((32'(s) * WAYS + 32'(w)) * WPL + 32'(k));
    endfunction

    function automatic logic [31:0] f_extract(logic [63:0] b, logic [1:0] lo,
                                              logic [2:0] s);
        return 32'(b >> {lo, 3'b000}) & size_mask(s);
    endfunction

    t_state        r_state, n_state;
    t_pend         r_pend, n_pend;
    logic [31:0]   r_paddr, n_paddr;
    logic [2:0]    r_psize, n_psize;
    logic [WW-1:0] r_fway, n_fway;
    logic [CW-1:0] r_fcnt, n_fcnt;
    logic [63:0]   r_buf, n_buf;
    logic [31:0]   r_look, n_look;
    logic [31:0]   r_addr, n_addr;
    logic [2:0]    r_size, n_size;
    logic          r_is_wr, n_is_wr;
    logic [63:0]   r_wd, n_wd;
    logic [7:0]    r_be, n_be;
    logic          r_need2, n_need2;
    logic          r_piece, n_piece;
    logic [DW-1:0] r_didx, n_didx;
    t_res          r_res, n_res;
    t_res          r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic [31:0]   r_dmem [DEPTH];
    logic [31:0]   r_drd;
    logic          d_we, d_re;
    logic [DW-1:0] d_wa, d_ra;
    logic [31:0]   d_wd;

    t_op           in_op;
    logic [31:0]   in_addr;
    logic [2:0]    in_size;
    logic [31:0]   in_data;
    logic          acc;
    logic          can_load;
    logic          in_uncached;
    logic          fill_last;
    logic          idle_emit;
    logic          idle_look;
    logic          next_piece;
    logic          tags_ready;
    logic          hit;
    logic [WW-1:0] hit_way;
    logic [WW-1:0] victim_way;
    logic          alloc;
    logic          fill_done;
    logic [31:0]   merged;
    t_res          wr_res;

    assign in_op       = t_op'(i_s_tuser);
    assign in_addr     = i_s_tdata[31:0];
    assign in_size     = clamp_size(i_s_tdata[34:32]);
    assign in_data     = i_s_tdata[66:35];
    assign o_s_tready  = (r_state == ST_IDLE) && tags_ready;
    assign acc         = i_s_tvalid && o_s_tready;
    assign can_load    = !r_out_valid || i_m_tready;
    assign in_uncached = in_addr[OB-1:0] > OB'(LINE_BYTES - 4);
    assign fill_last   = (r_fcnt == CW'(WPL - 1));
    assign next_piece  = r_need2 && !r_piece;

    assign idle_emit = acc && (
        (in_op == OP_RESP && (r_pend == PEND_UNC || (r_pend == PEND_FILL && fill_last))) ||
        (in_op == OP_READ && r_pend == PEND_NONE && in_uncached));
    assign idle_look = acc && r_pend == PEND_NONE &&
        ((in_op == OP_READ && !in_uncached) || in_op == OP_WRITE);

    assign wr_res = '{kind: KIND_WRITE, addr: r_addr, size: r_size,
                      data: 32'(r_wd >> {r_addr[1:0], 3'b000})};

    sacache_tags #(
        .SETS  (SETS),
        .WAYS  (WAYS),
        .TAG_W (TW)
    ) u_tags (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_set     (f_set(n_look)),
        .i_cmp_set    (f_set(r_look)),
        .i_cmp_tag    (f_tag(r_look)),
        .i_alloc      (alloc),
        .i_fill_done  (fill_done),
        .i_fill_set   (f_set(r_paddr)),
        .i_fill_way   (r_fway),
        .o_ready      (tags_ready),
        .o_hit        (hit),
        .o_hit_way    (hit_way),
        .o_victim_way (victim_way)
    );

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            merged[8*b +: 8] = r_be[4*r_piece + b] ? r_wd[32*r_piece + 8*b +: 8]
                                                    : r_drd[8*b +: 8];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (idle_emit) begin
                    n_state = ST_EMIT;
                end else if (idle_look) begin
                    n_state = ST_TAG;
                end
            end
            ST_TAG: begin
                if (hit) begin
                    n_state = ST_DATA;
                end else if (r_is_wr && next_piece) begin
                    n_state = ST_TAG;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DATA: begin
                if (!next_piece) begin
                    n_state = ST_EMIT;
                end else if (r_is_wr) begin
                    n_state = ST_TAG;
                end
            end
            ST_EMIT: begin
                if (can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_pend      = r_pend;
        n_paddr     = r_paddr;
        n_psize     = r_psize;
        n_fway      = r_fway;
        n_fcnt      = r_fcnt;
        n_buf       = r_buf;
        n_look      = r_look;
        n_addr      = r_addr;
        n_size      = r_size;
        n_is_wr     = r_is_wr;
        n_wd        = r_wd;
        n_be        = r_be;
        n_need2     = r_need2;
        n_piece     = r_piece;
        n_didx      = r_didx;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        d_we        = 1'b0;
        d_wa        = r_didx;
        d_wd        = merged;
        d_re        = 1'b0;
        d_ra        = r_didx;
        alloc       = 1'b0;
        fill_done   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    unique case (in_op)
                        OP_RESP: begin
                            if (r_pend == PEND_UNC) begin
                                n_pend = PEND_NONE;
                                n_res  = '{kind: KIND_DATA, addr: r_paddr, size: r_psize,
                                           data: in_data & size_mask(r_psize)};
                            end else if (r_pend == PEND_FILL) begin
                                d_we = 1'b1;
                                d_wa = f_didx(f_set(r_paddr), r_fway, r_fcnt);
                                d_wd = in_data;
                                if (r_fcnt == f_word(r_paddr)) begin
                                    n_buf[31:0] = in_data;
                                end
                                if (r_fcnt == f_word(r_paddr) + CW'(1)) begin
                                    n_buf[63:32] = in_data;
                                end
                                if (fill_last) begin
                                    fill_done = 1'b1;
                                    n_pend    = PEND_NONE;
                                    n_fcnt    = '0;
                                    n_res     = '{kind: KIND_DATA, addr: r_paddr,
                                                  size: r_psize,
                                                  data: f_extract(n_buf, r_paddr[1:0],
                                                                  r_psize)};
                                end else begin
                                    n_fcnt = r_fcnt + CW'(1);
                                end
                            end
                        end
                        OP_READ, OP_WRITE: begin
                            if (r_pend == PEND_NONE) begin
                                if (in_op == OP_READ && in_uncached) begin
                                    n_pend  = PEND_UNC;
                                    n_paddr = in_addr;
                                    n_psize = in_size;
                                    n_res   = '{kind: KIND_UNC, addr: in_addr, size: in_size,
                                                data: 32'd0};
                                end else begin
                                    n_look  = {in_addr[31:2], 2'b00};
                                    n_addr  = in_addr;
                                    n_size  = in_size;
                                    n_is_wr = (in_op == OP_WRITE);
                                    n_wd    = 64'(in_data & size_mask(in_size))
                                              << {in_addr[1:0], 3'b000};
                                    n_be    = 8'((9'd1 << in_size) - 9'd1) << in_addr[1:0];
                                    n_need2 = (4'(in_addr[1:0]) + 4'(in_size)) > 4'd4;
                                    n_piece = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TAG: begin
                if (hit) begin
                    d_re   = 1'b1;
                    d_ra   = f_didx(f_set(r_look), hit_way, f_word(r_look));
                    n_didx = d_ra;
                end else if (r_is_wr) begin
                    if (next_piece) begin
                        n_look  = r_look + 32'd4;
                        n_piece = 1'b1;
                    end else begin
                        n_res = wr_res;
                    end
                end else begin
                    alloc   = 1'b1;
                    n_fway  = victim_way;
                    n_fcnt  = '0;
                    n_pend  = PEND_FILL;
                    n_paddr = r_addr;
                    n_psize = r_size;
                    n_res   = '{kind: KIND_FILL, addr: {r_addr[31:OB], OB'(0)}, size: 3'd0,
                                data: 32'd0};
                end
            end
            ST_DATA: begin
                if (r_is_wr) begin
                    d_we = 1'b1;
                    d_wa = r_didx;
                    d_wd = merged;
                    if (next_piece) begin
                        n_look  = r_look + 32'd4;
                        n_piece = 1'b1;
                    end else begin
                        n_res = wr_res;
                    end
                end else begin
                    if (r_piece) begin
                        n_buf[63:32] = r_drd;
                    end else begin
                        n_buf[31:0] = r_drd;
                    end
                    if (next_piece) begin
                        n_look  = r_look + 32'd4;
                        n_piece = 1'b1;
                        d_re    = 1'b1;
                        d_ra    = r_didx + DW'(1);
                        n_didx  = d_ra;
                    end else begin
                        n_res = '{kind: KIND_DATA, addr: r_addr, size: r_size,
                                  data: f_extract(n_buf, r_addr[1:0], r_size)};
                    end
                end
            end
            ST_EMIT: begin
                if (can_load) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            r_dmem[d_wa] <= d_wd;
        end
        if (d_re) begin
            r_drd <= r_dmem[d_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= PEND_NONE;
            r_fcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_fcnt      <= n_fcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr <= n_paddr;
        r_psize <= n_psize;
        r_fway  <= n_fway;
        r_buf   <= n_buf;
        r_look  <= n_look;
        r_addr  <= n_addr;
        r_size  <= n_size;
        r_is_wr <= n_is_wr;
        r_wd    <= n_wd;
        r_be    <= n_be;
        r_need2 <= n_need2;
        r_piece <= n_piece;
        r_didx  <= n_didx;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {5'd0, r_out.data, r_out.size, r_out.addr};

endmodule
